// ===== rtl/core/bhc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bucket histogram counter package
// Shared widths, codes and beat types of the bucket histogram counter.
// ----------------------------------------------------------------------------
package bhc_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int FUNC_W    = 2;
  localparam int IDX_W     = 3;
  localparam int HIT_W     = 3;
  localparam int CUM_OUT_W = 32;
  localparam int TOT_OUT_W = 32;
  localparam int SUM_OUT_W = 48;
  localparam int EXT_W     = 64;

  localparam int DEF_NUM_BOUNDS  = 7;
  localparam int DEF_COUNT_WIDTH = 32;
  localparam int DEF_SUM_WIDTH   = 48;

  // Configuration register indexes: bounds sit at 0 upward, the count at 7.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKETS_IN_USE = 3'd7;
  localparam int CFG_DATA_W = 32;

  // Reported for a sample above every active bound, and the read-all index.
  localparam logic [HIT_W-1:0] HIT_NONE  = 3'd7;
  localparam logic [IDX_W-1:0] IDX_TOTAL = 3'd7;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_OBSERVE = 2'd0,
    FUNC_READ    = 2'd1,
    FUNC_CLEAR   = 2'd2
  } func_t;

  typedef struct packed {
    logic [FUNC_W-1:0]          func;
    logic signed [SAMPLE_W-1:0] sample;
    logic [IDX_W-1:0]           bucket_index;
  } item_t;

  typedef struct packed {
    logic             found;
    logic [HIT_W-1:0] bucket;
  } hit_t;

  typedef struct packed {
    logic [HIT_W-1:0]            bucket_hit;
    logic [CUM_OUT_W-1:0]        cumulative_count;
    logic [TOT_OUT_W-1:0]        total_count;
    logic signed [SUM_OUT_W-1:0] sample_sum;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/bhc_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bucket histogram input channel
// Valid/ready channel that carries one operation beat.
// ----------------------------------------------------------------------------
interface bhc_in_if import bhc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [FUNC_W-1:0]          func;
  logic signed [SAMPLE_W-1:0] sample;
  logic [IDX_W-1:0]           bucket_index;

  modport source(output valid, func, sample, bucket_index, input ready);
  modport sink(input valid, func, sample, bucket_index, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bhc_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bucket histogram result channel
// Valid/ready channel that carries one result beat.
// ----------------------------------------------------------------------------
interface bhc_out_if import bhc_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [HIT_W-1:0]            bucket_hit;
  logic [CUM_OUT_W-1:0]        cumulative_count;
  logic [TOT_OUT_W-1:0]        total_count;
  logic signed [SUM_OUT_W-1:0] sample_sum;

  modport source(output valid, bucket_hit, cumulative_count, total_count, sample_sum,
                 input ready);
  modport sink(input valid, bucket_hit, cumulative_count, total_count, sample_sum,
               output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bucket_histogram_counter_core.sv =====
`default_nettype none
// A result beat passes through the input register and then the result register.
// Throughput: one item per cycle; the input register hands to the result
// register whenever that register is empty or being drained in the same cycle.
// The state update and result come from the comparators and adders between them.
// Reset clears all counters, the sum, the bounds, buckets_in_use and both valids.
// ----------------------------------------------------------------------------
// Bucket histogram counter core
// Histogram of Q16.16 samples against configurable upper bounds, with
// saturating bucket counters, total count and running sum.
// ----------------------------------------------------------------------------
module bucket_histogram_counter_core import bhc_pkg::*; #(
  parameter int NUM_BOUNDS  = DEF_NUM_BOUNDS,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
  parameter int SUM_WIDTH   = DEF_SUM_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bhc_in_if.sink                in_ch,
  bhc_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic signed [SAMPLE_W-1:0] bounds_r [NUM_BOUNDS];
  logic [IDX_W-1:0]           in_use_r;
  logic [IDX_W-1:0]           n_active;

  logic    s0_valid_r;
  logic    s0_valid_nxt;
  item_t   s0_item_r;
  logic    out_valid_r;
  logic    out_valid_nxt;
  result_t out_r;
  result_t result;
  hit_t    hit;
  logic    in_fire;
  logic    advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BOUNDS; i++) begin
        bounds_r[i] <= '0;
      end
      in_use_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_BUCKETS_IN_USE) begin
        in_use_r <= cfg_wdata[IDX_W-1:0];
      end
      for (int i = 0; i < NUM_BOUNDS; i++) begin
        if (cfg_index == CFG_IDX_W'(i)) begin
          bounds_r[i] <= cfg_wdata;
        end
      end
    end
  end

  assign n_active = (in_use_r > IDX_W'(NUM_BOUNDS)) ? IDX_W'(NUM_BOUNDS) : in_use_r;

  // Handshake: the input register moves on whenever the result register frees.
  assign advance     = s0_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s0_valid_r || !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    s0_valid_nxt = s0_valid_r;
    if (in_fire) begin
      s0_valid_nxt = 1'b1;
    end else if (advance) begin
      s0_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s0_valid_r  <= s0_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_item_r.func         <= in_ch.func;
      s0_item_r.sample       <= in_ch.sample;
      s0_item_r.bucket_index <= in_ch.bucket_index;
    end
    if (advance) begin
      out_r <= result;
    end
  end

  bhc_bucket_search #(
    .NUM_BOUNDS(NUM_BOUNDS)
  ) u_search (
    .bounds  (bounds_r),
    .n_active(n_active),
    .sample  (s0_item_r.sample),
    .hit     (hit)
  );

  bhc_stat_state #(
    .NUM_BOUNDS (NUM_BOUNDS),
    .COUNT_WIDTH(COUNT_WIDTH),
    .SUM_WIDTH  (SUM_WIDTH)
  ) u_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (s0_item_r),
    .hit     (hit),
    .n_active(n_active),
    .result  (result)
  );

  assign out_ch.valid            = out_valid_r;
  assign out_ch.bucket_hit       = out_r.bucket_hit;
  assign out_ch.cumulative_count = out_r.cumulative_count;
  assign out_ch.total_count      = out_r.total_count;
  assign out_ch.sample_sum       = out_r.sample_sum;

endmodule
`default_nettype wire

// ===== rtl/core/bhc_bucket_search.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bucket search
// Parallel bound comparators feeding a priority encoder.
// ----------------------------------------------------------------------------
module bhc_bucket_search import bhc_pkg::*; #(
  parameter int NUM_BOUNDS = DEF_NUM_BOUNDS
) (
  input  logic signed [SAMPLE_W-1:0] bounds [NUM_BOUNDS],
  input  logic [IDX_W-1:0]           n_active,
  input  logic signed [SAMPLE_W-1:0] sample,
  output hit_t                       hit
);

  // The lowest-numbered active bound that is not below the sample wins.
  always_comb begin
    hit.found  = 1'b0;
    hit.bucket = HIT_NONE;
    for (int i = NUM_BOUNDS - 1; i >= 0; i--) begin
      if ((IDX_W'(i) < n_active) && (bounds[i] >= sample)) begin
        hit.found  = 1'b1;
        hit.bucket = HIT_W'(i);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/bhc_stat_state.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Histogram statistics state
// Bucket counters, total count and running sum with saturating updates,
// plus the cumulative read and the result beat formatting.
// ----------------------------------------------------------------------------
module bhc_stat_state import bhc_pkg::*; #(
  parameter int NUM_BOUNDS  = DEF_NUM_BOUNDS,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
  parameter int SUM_WIDTH   = DEF_SUM_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  item_t            item,
  input  hit_t             hit,
  input  logic [IDX_W-1:0] n_active,
  output result_t          result
);

  localparam int ACC_W = COUNT_WIDTH + 3;
  localparam int SW1   = SUM_WIDTH + 1;
  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  logic [COUNT_WIDTH-1:0]        count_r [NUM_BOUNDS];
  logic [COUNT_WIDTH-1:0]        total_r;
  logic [COUNT_WIDTH-1:0]        total_nxt;
  logic signed [SUM_WIDTH-1:0]   sum_r;
  logic signed [SUM_WIDTH-1:0]   sum_nxt;
  logic signed [SW1-1:0]         sum_wide;
  logic [ACC_W-1:0]              cum_acc;
  logic [COUNT_WIDTH-1:0]        cum_sat;
  logic [COUNT_WIDTH-1:0]        cum_val;
  logic [EXT_W-1:0]              cum_ext;
  logic [EXT_W-1:0]              total_cur_ext;
  logic [EXT_W-1:0]              total_nxt_ext;
  logic signed [EXT_W-1:0]       sum_cur_ext;
  logic signed [EXT_W-1:0]       sum_nxt_ext;
  logic                          is_observe;
  logic                          is_clear;

  assign is_observe = step_en && (item.func == FUNC_OBSERVE);
  assign is_clear   = step_en && (item.func == FUNC_CLEAR);

  assign total_nxt = (&total_r) ? total_r : total_r + COUNT_WIDTH'(1);

  // One extra bit shows whether the signed add left the sum's range.
  always_comb begin
    sum_wide = SW1'(sum_r) + SW1'(item.sample);
    if (sum_wide[SW1-1] != sum_wide[SW1-2]) begin
      sum_nxt = sum_wide[SW1-1] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_nxt = sum_wide[SUM_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || is_clear) begin
      for (int i = 0; i < NUM_BOUNDS; i++) begin
        count_r[i] <= '0;
      end
      total_r <= '0;
      sum_r   <= '0;
    end else if (is_observe) begin
      for (int i = 0; i < NUM_BOUNDS; i++) begin
        if (hit.found && (hit.bucket == HIT_W'(i)) && !(&count_r[i])) begin
          count_r[i] <= count_r[i] + COUNT_WIDTH'(1);
        end
      end
      total_r <= total_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // Counters are never negative, so one clamp after a wide add matches
  // saturating after every step.
  always_comb begin
    cum_acc = '0;
    for (int i = 0; i < NUM_BOUNDS; i++) begin
      if (IDX_W'(i) <= item.bucket_index) begin
        cum_acc = cum_acc + ACC_W'(count_r[i]);
      end
    end
    cum_sat = (|cum_acc[ACC_W-1:COUNT_WIDTH]) ? '1 : cum_acc[COUNT_WIDTH-1:0];
    if ((item.bucket_index == IDX_TOTAL) || (item.bucket_index >= n_active)) begin
      cum_val = total_r;
    end else begin
      cum_val = cum_sat;
    end
  end

  assign cum_ext       = EXT_W'(cum_val);
  assign total_cur_ext = EXT_W'(total_r);
  assign total_nxt_ext = EXT_W'(total_nxt);
  assign sum_cur_ext   = EXT_W'(sum_r);
  assign sum_nxt_ext   = EXT_W'(sum_nxt);

  always_comb begin
    result.bucket_hit       = '0;
    result.cumulative_count = '0;
    result.total_count      = total_cur_ext[TOT_OUT_W-1:0];
    result.sample_sum       = sum_cur_ext[SUM_OUT_W-1:0];
    case (item.func)
      FUNC_OBSERVE: begin
        result.bucket_hit  = hit.bucket;
        result.total_count = total_nxt_ext[TOT_OUT_W-1:0];
        result.sample_sum  = sum_nxt_ext[SUM_OUT_W-1:0];
      end
      FUNC_READ: begin
        result.cumulative_count = cum_ext[CUM_OUT_W-1:0];
      end
      FUNC_CLEAR: begin
        result.total_count = '0;
        result.sample_sum  = '0;
      end
      default: begin
        result.bucket_hit = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== tb/bucket_histogram_counter_core_tb.sv =====
// ----------------------------------------------------------------------------
// Bucket histogram counter testbench
// Drives observe, read, clear and unused beats into the core under several
// bound settings, predicts every result beat from its own copy of the
// bounds, counters and sum, and checks each result beat field by field.
// Both channels idle at random, and back-to-back runs of extreme samples
// push the running sum hard in both directions.
// ----------------------------------------------------------------------------
module bucket_histogram_counter_core_tb;
  import bhc_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 11;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_LIMIT  = 1000;
  localparam int GAP_MAX      = 6;
  localparam int NUM_PHASES   = 6;
  localparam int PHASE_ITEMS  = 320;
  localparam int SAT_RUN      = 40;
  localparam int SHOW_MAX     = 10;

  localparam logic [FUNC_W-1:0]    FUNC_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_0 = 3'd0;
  localparam logic signed [SAMPLE_W-1:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [SAMPLE_W-1:0] S32_MAX = 32'sh7FFF_FFFF;

  typedef enum int {SHAPE_SPREAD, SHAPE_TIGHT, SHAPE_SHUFFLED, SHAPE_EXTREME} bound_shape_t;

  class hist_scoreboard;
    logic signed [SAMPLE_W-1:0] bound_q [DEF_NUM_BOUNDS];
    logic [2:0]                 active_cnt;
    logic [TOT_OUT_W-1:0]       bucket_cnt [DEF_NUM_BOUNDS];
    logic [TOT_OUT_W-1:0]       sample_cnt;
    logic [SUM_OUT_W-1:0]       sum_acc;
    result_t                    pending_results [$];
    int                         mismatches;

    function new();
      foreach (bound_q[i]) bound_q[i] = '0;
      active_cnt = '0;
      mismatches = 0;
      clear_counts();
    endfunction

    function void clear_counts();
      foreach (bucket_cnt[i]) bucket_cnt[i] = '0;
      sample_cnt = '0;
      sum_acc    = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_BUCKETS_IN_USE) begin
        active_cnt = data[2:0];
      end else begin
        bound_q[idx] = data;
      end
    endfunction

    function logic [TOT_OUT_W-1:0] sat_inc(logic [TOT_OUT_W-1:0] v);
      return (&v) ? v : v + 1'b1;
    endfunction

    function void note_item(item_t it);
      result_t              exp;
      logic [HIT_W-1:0]     hit;
      logic                 found;
      logic [TOT_OUT_W+2:0] cum_wide;
      logic [SUM_OUT_W:0]   sum_wide;
      exp = '0;
      case (it.func)
        FUNC_OBSERVE: begin
          found = 1'b0;
          hit   = HIT_NONE;
          // Priority over the active bounds; order of the bounds is not assumed.
          for (int i = 0; i < DEF_NUM_BOUNDS; i++) begin
            if (!found && i < active_cnt && $signed(bound_q[i]) >= $signed(it.sample)) begin
              found = 1'b1;
              hit   = HIT_W'(i);
            end
          end
          if (found) bucket_cnt[hit] = sat_inc(bucket_cnt[hit]);
          sample_cnt = sat_inc(sample_cnt);
          sum_wide = {sum_acc[SUM_OUT_W-1], sum_acc}
                   + {{(SUM_OUT_W-SAMPLE_W+1){it.sample[SAMPLE_W-1]}}, it.sample};
          // The two top bits disagree only when the sum left the signed range.
          if (sum_wide[SUM_OUT_W] != sum_wide[SUM_OUT_W-1]) begin
            sum_acc = sum_wide[SUM_OUT_W] ? {1'b1, {(SUM_OUT_W-1){1'b0}}}
                                          : {1'b0, {(SUM_OUT_W-1){1'b1}}};
          end else begin
            sum_acc = sum_wide[SUM_OUT_W-1:0];
          end
          exp.bucket_hit = hit;
        end
        FUNC_READ: begin
          if (it.bucket_index == IDX_TOTAL || it.bucket_index >= active_cnt) begin
            exp.cumulative_count = sample_cnt;
          end else begin
            cum_wide = '0;
            for (int i = 0; i <= it.bucket_index; i++) cum_wide += bucket_cnt[i];
            exp.cumulative_count = (|cum_wide[TOT_OUT_W+2:TOT_OUT_W]) ? '1
                                                                      : cum_wide[TOT_OUT_W-1:0];
          end
        end
        FUNC_CLEAR: clear_counts();
        default: ;
      endcase
      exp.total_count = sample_cnt;
      exp.sample_sum  = sum_acc;
      pending_results = {pending_results, exp};
    endfunction

    function void log_mismatch(string what, result_t exp, result_t got);
      mismatches++;
      if (mismatches <= SHOW_MAX) begin
        $display("ERROR %0s: expected hit=%0d cum=%0d total=%0d sum=%h",
                 what, exp.bucket_hit, exp.cumulative_count, exp.total_count, exp.sample_sum);
        $display("      %0s    actual hit=%0d cum=%0d total=%0d sum=%h",
                 what, got.bucket_hit, got.cumulative_count, got.total_count, got.sample_sum);
      end
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (pending_results.size() == 0) begin
        log_mismatch("result beat with nothing pending", '0, got);
        return;
      end
      exp = pending_results.pop_front();
      if (exp.bucket_hit !== got.bucket_hit || exp.cumulative_count !== got.cumulative_count ||
          exp.total_count !== got.total_count || exp.sample_sum !== got.sample_sum) begin
        log_mismatch("result beat", exp, got);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    gap_max   = GAP_MAX;
  int                    stall_max = GAP_MAX;
  int                    cycle_cnt = 0;
  logic signed [SAMPLE_W-1:0] cfg_next [DEF_NUM_BOUNDS];
  hist_scoreboard        hist_sb;

  bhc_in_if  in_ch ();
  bhc_out_if out_ch ();

  bucket_histogram_counter_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Both beats are taken from the values that stood just before the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        hist_sb.note_item(item_t'({in_ch.func, in_ch.sample, in_ch.bucket_index}));
      end
      if (out_ch.valid && out_ch.ready) begin
        hist_sb.check_result(result_t'({out_ch.bucket_hit, out_ch.cumulative_count,
                                        out_ch.total_count, out_ch.sample_sum}));
      end
    end
  end

  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = $urandom_range(stall_max, 0);
      repeat (stall) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [SAMPLE_W-1:0] s,
                           input logic [IDX_W-1:0] idx);
    int gap;
    gap = $urandom_range(gap_max, 0);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.func         <= f;
    in_ch.sample       <= s;
    in_ch.bucket_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Holds the input side off until every pending result beat has come back.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (hist_sb.pending_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic drive_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    hist_sb.write_reg(idx, data);
  endtask

  task automatic load_config(input logic [2:0] n);
    settle();
    for (int i = 0; i < DEF_NUM_BOUNDS; i++) drive_reg(REG_BOUND_0 + CFG_IDX_W'(i), cfg_next[i]);
    drive_reg(REG_BUCKETS_IN_USE, CFG_DATA_W'(n));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic pick_bounds(input bound_shape_t shape);
    int v;
    case (shape)
      SHAPE_SPREAD: begin
        v = int'($urandom) >>> 3;
        cfg_next[0] = v;
        for (int i = 1; i < DEF_NUM_BOUNDS; i++) begin
          v += int'($urandom_range(1 << 27, 1));
          cfg_next[i] = v;
        end
      end
      SHAPE_TIGHT: begin
        // Bounds a few LSBs apart around zero, so neighbors are easy to straddle.
        v = int'($urandom_range(64, 0)) - 32;
        cfg_next[0] = v;
        for (int i = 1; i < DEF_NUM_BOUNDS; i++) begin
          v += int'($urandom_range(8, 1));
          cfg_next[i] = v;
        end
      end
      SHAPE_SHUFFLED: begin
        foreach (cfg_next[i]) cfg_next[i] = $urandom;
      end
      default: begin
        foreach (cfg_next[i]) cfg_next[i] = $urandom_range(1, 0) ? S32_MAX : S32_MIN;
      end
    endcase
  endtask

  task automatic send_random();
    int                  r;
    int                  k;
    logic [FUNC_W-1:0]   f;
    logic [SAMPLE_W-1:0] s;
    r = $urandom_range(99, 0);
    if (r < 62) f = FUNC_OBSERVE;
    else if (r < 91) f = FUNC_READ;
    else if (r < 94) f = FUNC_CLEAR;
    else f = FUNC_UNUSED;
    r = $urandom_range(99, 0);
    k = $urandom_range(DEF_NUM_BOUNDS - 1, 0);
    if (r < 35) begin
      s = $urandom;
    end else if (r < 70) begin
      s = hist_sb.bound_q[k] + $urandom_range(2, 0) - 1;
    end else if (r < 90) begin
      s = $urandom_range(1 << 20, 0);
      if ($urandom_range(1, 0)) s = -s;
    end else begin
      case ($urandom_range(3, 0))
        0: s = S32_MIN;
        1: s = S32_MAX;
        2: s = '0;
        default: s = '1;
      endcase
    end
    send_item(f, s, IDX_W'($urandom_range(7, 0)));
  endtask

  initial begin : stimulus
    int waited;
    logic [2:0] n;
    hist_sb            = new();
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.func         = FUNC_OBSERVE;
    in_ch.sample       = '0;
    in_ch.bucket_index = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Ascending bounds across the full range, all seven buckets active.
    cfg_next = '{S32_MIN, -32'sd65536, 32'sd0, 32'sd65536, 32'sd1048576, 32'sd1073741824,
                 S32_MAX};
    load_config(3'd7);
    send_item(FUNC_OBSERVE, S32_MIN, '0);
    send_item(FUNC_OBSERVE, S32_MAX, '0);
    send_item(FUNC_OBSERVE, 32'sd0, '0);
    send_item(FUNC_OBSERVE, -32'sd1, '0);
    send_item(FUNC_OBSERVE, 32'sd65537, '0);
    send_item(FUNC_READ, '0, 3'd0);
    send_item(FUNC_READ, '0, 3'd3);
    send_item(FUNC_READ, '0, 3'd6);
    send_item(FUNC_READ, '0, IDX_TOTAL);
    send_item(FUNC_UNUSED, S32_MAX, IDX_TOTAL);
    send_item(FUNC_CLEAR, S32_MIN, 3'd2);
    send_item(FUNC_READ, '0, IDX_TOTAL);

    // Unsorted bounds with three active; the disabled ones would catch anything.
    cfg_next = '{32'sd1310720, -32'sd327680, 32'sd3276800, S32_MAX, S32_MAX, S32_MAX, S32_MAX};
    load_config(3'd3);
    send_item(FUNC_OBSERVE, 32'sd1966080, '0);
    send_item(FUNC_OBSERVE, -32'sd655360, '0);
    send_item(FUNC_OBSERVE, 32'sd3932160, '0);
    send_item(FUNC_READ, '0, 3'd1);
    send_item(FUNC_READ, '0, 3'd2);
    send_item(FUNC_READ, '0, 3'd5);

    // No active bucket: every sample lands above all bounds.
    load_config(3'd0);
    send_item(FUNC_OBSERVE, 32'sd0, '0);
    send_item(FUNC_READ, '0, 3'd0);

    // Back-to-back extreme samples drive the sum far out in both directions.
    gap_max   = 0;
    stall_max = 0;
    send_item(FUNC_CLEAR, '0, '0);
    repeat (SAT_RUN) send_item(FUNC_OBSERVE, S32_MAX, '0);
    send_item(FUNC_READ, '0, IDX_TOTAL);
    send_item(FUNC_CLEAR, '0, '0);
    repeat (SAT_RUN) send_item(FUNC_OBSERVE, S32_MIN, '0);
    send_item(FUNC_READ, '0, IDX_TOTAL);

    for (int p = 0; p < NUM_PHASES; p++) begin
      pick_bounds(bound_shape_t'(p % 4));
      n = (p == 1) ? 3'd0 : (p % 3 == 0) ? 3'd7 : 3'($urandom_range(6, 1));
      load_config(n);
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        // Every fourth stretch of fifty beats runs with no idling on either side.
        gap_max   = ((j / 50) % 4 == 3) ? 0 : GAP_MAX;
        stall_max = gap_max;
        if (j % 120 == 60) settle();
        send_random();
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    waited = 0;
    while (hist_sb.pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (4) @(negedge clk);
    if (hist_sb.mismatches == 0 && hist_sb.pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
